// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker module tgei_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication failed");

// Implication with a fixed delay, disabled during reset.
`define ASSERT_DELAY(label, clk, rst, ante, n, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
      else $error("%m: delayed implication failed");

`endif

// ===== rtl/core/tgei_pkg.sv =====
`timescale 1ns / 1ps
package tgei_pkg;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_AREA    = 2'd2,
      STATUS_DET     = 2'd3
   } status_type;

   // Register indexes on the csr port.
   localparam int CSR_MIN_AREA = 0;
   localparam int CSR_MIN_DET  = 1;
   localparam int CSR_WIDTH    = 32;
   localparam int OUT_WIDTH    = 32;

   // Quotient bits kept before saturation, and root bits produced.
   localparam int Q_BITS       = 64;
   localparam int ROOT_BITS    = 32;
   localparam int FRONT_STAGES = 8;
   localparam int PIPE_LAT     = FRONT_STAGES + Q_BITS + ROOT_BITS + 1;

   // Sideband that travels with each word.
   typedef struct packed {
      logic       valid;
      status_type status;
      logic       sat;
   } tag_type;

endpackage

// ===== rtl/core/triangle_gradient_error_indicator.sv =====
`timescale 1ns / 1ps
// Channel   Ports                        Handshake
// request   req_* fields, start, busy    taken when start is high and busy is low
// response  rsp_* fields, rsp_valid      one-cycle strobe, always taken
// csr       csr_we, csr_index, csr_wdata write on any edge with csr_we high
//
// One word enters every cycle while busy is low; each result passes the front stages,
// the 64-stage quotient pipeline, the 32-stage root pipeline and the output register.
// Reset is synchronous; busy follows reset, and reset flushes all words in flight.
// The pipeline never stalls, since the receiver cannot hold results off.
module triangle_gradient_error_indicator #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_element_valid,
   input  logic signed [COORD_WIDTH-1:0]       req_x0,
   input  logic signed [COORD_WIDTH-1:0]       req_y0,
   input  logic signed [COORD_WIDTH-1:0]       req_x1,
   input  logic signed [COORD_WIDTH-1:0]       req_y1,
   input  logic signed [COORD_WIDTH-1:0]       req_x2,
   input  logic signed [COORD_WIDTH-1:0]       req_y2,
   input  logic signed [COORD_WIDTH-1:0]       req_u0,
   input  logic signed [COORD_WIDTH-1:0]       req_u1,
   input  logic signed [COORD_WIDTH-1:0]       req_u2,
   output logic                                rsp_valid,
   output logic [tgei_pkg::OUT_WIDTH-1:0]      rsp_error_indicator,
   output logic [1:0]                          rsp_status,
   output logic                                rsp_saturated,
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic [tgei_pkg::CSR_WIDTH-1:0]      csr_wdata
);
   import tgei_pkg::*;

   localparam int EW  = COORD_WIDTH + 1;
   localparam int PW  = 2 * EW;
   localparam int DW  = PW + 1;
   localparam int MW  = DW;
   localparam int HW  = (MW + 1) / 2;
   localparam int LW  = MW - HW;
   localparam int SW  = 2 * MW;
   localparam int NW  = 2 * MW + 1;
   localparam int MTW = MW + 1;
   localparam int HIW = NW - Q_BITS;
   localparam int CW  = (HIW > MTW) ? HIW : MTW;
   localparam int FW  = (MW > CSR_WIDTH + 1) ? MW : CSR_WIDTH + 1;

   // Configuration registers.
   logic [CSR_WIDTH-1:0] min_area_ff;
   logic [CSR_WIDTH-1:0] min_det_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_area_ff <= CSR_WIDTH'(1);
         min_det_ff  <= CSR_WIDTH'(1);
      end else if (csr_we) begin
         if (csr_index == 1'(CSR_MIN_AREA)) begin
            min_area_ff <= csr_wdata;
         end
         if (csr_index == 1'(CSR_MIN_DET)) begin
            min_det_ff <= csr_wdata;
         end
      end
   end

   assign busy = reset;

   tag_type tag1_ff, tag2_ff, tag3_ff, tag4_ff, tag5_ff, tag6_ff, tag7_ff, tag8_ff;
   tag_type tag1_in, tag5_in, tag8_in;

   // Stage 1: edge vectors and value differences from vertex 0.
   logic signed [EW-1:0] ax_ff, ay_ff, bx_ff, by_ff, du1_ff, du2_ff;

   always_comb begin
      tag1_in        = '0;
      tag1_in.valid  = start && !busy;
      tag1_in.status = req_element_valid ? STATUS_OK : STATUS_INVALID;
   end

   always_ff @(posedge clock) begin
      ax_ff  <= EW'(req_x1) - EW'(req_x0);
      ay_ff  <= EW'(req_y1) - EW'(req_y0);
      bx_ff  <= EW'(req_x2) - EW'(req_x0);
      by_ff  <= EW'(req_y2) - EW'(req_y0);
      du1_ff <= EW'(req_u1) - EW'(req_u0);
      du2_ff <= EW'(req_u2) - EW'(req_u0);
   end

   // Stage 2: the six cross products.
   logic signed [PW-1:0] p_axby_ff, p_bxay_ff, p_bydu1_ff, p_aydu2_ff, p_axdu2_ff, p_bxdu1_ff;

   always_ff @(posedge clock) begin
      p_axby_ff  <= PW'(ax_ff) * PW'(by_ff);
      p_bxay_ff  <= PW'(bx_ff) * PW'(ay_ff);
      p_bydu1_ff <= PW'(by_ff) * PW'(du1_ff);
      p_aydu2_ff <= PW'(ay_ff) * PW'(du2_ff);
      p_axdu2_ff <= PW'(ax_ff) * PW'(du2_ff);
      p_bxdu1_ff <= PW'(bx_ff) * PW'(du1_ff);
   end

   // Stage 3: determinant and the two gradient numerators.
   logic signed [DW-1:0] det_ff, gx_ff, gy_ff;

   always_ff @(posedge clock) begin
      det_ff <= DW'(p_axby_ff) - DW'(p_bxay_ff);
      gx_ff  <= DW'(p_bydu1_ff) - DW'(p_aydu2_ff);
      gy_ff  <= DW'(p_axdu2_ff) - DW'(p_bxdu1_ff);
   end

   // Stage 4: magnitudes.
   logic [MW-1:0] dmag_ff, gxmag_ff, gymag_ff;

   always_ff @(posedge clock) begin
      dmag_ff  <= det_ff[DW-1] ? MW'(-det_ff) : MW'(det_ff);
      gxmag_ff <= gx_ff[DW-1] ? MW'(-gx_ff) : MW'(gx_ff);
      gymag_ff <= gy_ff[DW-1] ? MW'(-gy_ff) : MW'(gy_ff);
   end

   // Stage 5: floor checks and partial products of the two squares.
   logic [FW-1:0]      dmag_ext, area_lim, det_lim;
   logic [MW-1:0]      dmag5_ff;
   logic [2*HW-1:0]    xll_ff, yll_ff;
   logic [HW+LW-1:0]   xlh_ff, ylh_ff;
   logic [2*LW-1:0]    xhh_ff, yhh_ff;

   always_comb begin
      dmag_ext = FW'(dmag_ff);
      area_lim = FW'({min_area_ff, 1'b0});
      det_lim  = FW'(min_det_ff);
      tag5_in  = tag4_ff;
      if (tag4_ff.status == STATUS_OK) begin
         if (dmag_ext < area_lim) begin
            tag5_in.status = STATUS_AREA;
         end else if (dmag_ext < det_lim || dmag_ff == '0) begin
            tag5_in.status = STATUS_DET;
         end
      end
   end

   always_ff @(posedge clock) begin
      dmag5_ff <= dmag_ff;
      xll_ff   <= (2*HW)'(gxmag_ff[HW-1:0]) * (2*HW)'(gxmag_ff[HW-1:0]);
      xlh_ff   <= (HW+LW)'(gxmag_ff[HW-1:0]) * (HW+LW)'(gxmag_ff[MW-1:HW]);
      xhh_ff   <= (2*LW)'(gxmag_ff[MW-1:HW]) * (2*LW)'(gxmag_ff[MW-1:HW]);
      yll_ff   <= (2*HW)'(gymag_ff[HW-1:0]) * (2*HW)'(gymag_ff[HW-1:0]);
      ylh_ff   <= (HW+LW)'(gymag_ff[HW-1:0]) * (HW+LW)'(gymag_ff[MW-1:HW]);
      yhh_ff   <= (2*LW)'(gymag_ff[MW-1:HW]) * (2*LW)'(gymag_ff[MW-1:HW]);
   end

   // Stage 6: assemble the squares; the cross term counts twice.
   logic [SW-1:0] sqx_ff, sqy_ff;
   logic [MW-1:0] dmag6_ff;

   always_ff @(posedge clock) begin
      dmag6_ff <= dmag5_ff;
      sqx_ff   <= (SW'(xhh_ff) << (2*HW)) + (SW'(xlh_ff) << (HW+1)) + SW'(xll_ff);
      sqy_ff   <= (SW'(yhh_ff) << (2*HW)) + (SW'(ylh_ff) << (HW+1)) + SW'(yll_ff);
   end

   // Stage 7: numerator sum and twice the determinant magnitude.
   logic [NW-1:0]  num_ff;
   logic [MTW-1:0] den_ff;

   always_ff @(posedge clock) begin
      num_ff <= NW'(sqx_ff) + NW'(sqy_ff);
      den_ff <= {dmag6_ff, 1'b0};
   end

   // Stage 8: a quotient of 2^64 or more saturates; otherwise the high part seeds
   // the remainder.
   logic [CW-1:0]     hi_ext, den_ext;
   logic [MTW-1:0]    rem8_ff, den8_ff;
   logic [Q_BITS-1:0] nlo8_ff;

   always_comb begin
      hi_ext      = CW'(num_ff[NW-1:Q_BITS]);
      den_ext     = CW'(den_ff);
      tag8_in     = tag7_ff;
      tag8_in.sat = (hi_ext >= den_ext);
   end

   always_ff @(posedge clock) begin
      rem8_ff <= hi_ext[MTW-1:0];
      den8_ff <= den_ff;
      nlo8_ff <= num_ff[Q_BITS-1:0];
   end

   // Sideband registers of the front stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
         tag4_ff <= '0;
         tag5_ff <= '0;
         tag6_ff <= '0;
         tag7_ff <= '0;
         tag8_ff <= '0;
      end else begin
         tag1_ff <= tag1_in;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
         tag4_ff <= tag3_ff;
         tag5_ff <= tag5_in;
         tag6_ff <= tag5_ff;
         tag7_ff <= tag6_ff;
         tag8_ff <= tag8_in;
      end
   end

   // Quotient and square root pipelines.
   tag_type              div_tag, root_tag;
   logic [Q_BITS-1:0]    quot;
   logic [ROOT_BITS-1:0] root;

   tgei_div_pipe #(
      .MTW (MTW)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .in_tag  (tag8_ff),
      .in_rem  (rem8_ff),
      .in_nlo  (nlo8_ff),
      .in_m    (den8_ff),
      .out_tag (div_tag),
      .out_q   (quot)
   );

   tgei_sqrt_pipe u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .in_tag   (div_tag),
      .in_x     (quot),
      .out_tag  (root_tag),
      .out_root (root)
   );

   // Output word register.
   logic                 out_valid_ff;
   logic [OUT_WIDTH-1:0] out_value_ff;
   logic [1:0]           out_status_ff;
   logic                 out_sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= root_tag.valid;
      end
   end

   always_ff @(posedge clock) begin
      out_status_ff <= root_tag.status;
      out_sat_ff    <= (root_tag.status == STATUS_OK) && root_tag.sat;
      if (root_tag.status != STATUS_OK) begin
         out_value_ff <= '0;
      end else if (root_tag.sat) begin
         out_value_ff <= '1;
      end else begin
         out_value_ff <= OUT_WIDTH'(root);
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_error_indicator = out_value_ff;
   assign rsp_status          = out_status_ff;
   assign rsp_saturated       = out_sat_ff;

endmodule

// ===== rtl/core/tgei_div_pipe.sv =====
`timescale 1ns / 1ps
module tgei_div_pipe #(
   parameter int MTW = 68
) (
   input  logic                      clock,
   input  logic                      reset,
   input  tgei_pkg::tag_type         in_tag,
   input  logic [MTW-1:0]            in_rem,
   input  logic [tgei_pkg::Q_BITS-1:0] in_nlo,
   input  logic [MTW-1:0]            in_m,
   output tgei_pkg::tag_type         out_tag,
   output logic [tgei_pkg::Q_BITS-1:0] out_q
);
   import tgei_pkg::*;

   tag_type           tag_ff [0:Q_BITS-1];
   logic [MTW-1:0]    rem_ff [0:Q_BITS-1];
   logic [Q_BITS-1:0] nlo_ff [0:Q_BITS-1];
   logic [Q_BITS-1:0] q_ff   [0:Q_BITS-1];
   logic [MTW-1:0]    m_ff   [0:Q_BITS-1];

   tag_type           tag_pipe [0:Q_BITS];
   logic [MTW-1:0]    rem_pipe [0:Q_BITS];
   logic [Q_BITS-1:0] nlo_pipe [0:Q_BITS];
   logic [Q_BITS-1:0] q_pipe   [0:Q_BITS];
   logic [MTW-1:0]    m_pipe   [0:Q_BITS];

   assign tag_pipe[0] = in_tag;
   assign rem_pipe[0] = in_rem;
   assign nlo_pipe[0] = in_nlo;
   assign q_pipe[0]   = '0;
   assign m_pipe[0]   = in_m;

   // One restoring division step per stage, most significant quotient bit first.
   for (genvar k = 0; k < Q_BITS; k++) begin : g_step
      logic [MTW:0]   trial;
      logic [MTW:0]   diff;
      logic           take;
      logic [MTW-1:0] rem_in;

      always_comb begin
         trial  = {rem_pipe[k], nlo_pipe[k][Q_BITS-1]};
         diff   = trial - {1'b0, m_pipe[k]};
         take   = (trial >= {1'b0, m_pipe[k]});
         rem_in = take ? diff[MTW-1:0] : trial[MTW-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[k] <= '0;
         end else begin
            tag_ff[k] <= tag_pipe[k];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k] <= rem_in;
         nlo_ff[k] <= {nlo_pipe[k][Q_BITS-2:0], 1'b0};
         q_ff[k]   <= {q_pipe[k][Q_BITS-2:0], take};
         m_ff[k]   <= m_pipe[k];
      end

      assign tag_pipe[k+1] = tag_ff[k];
      assign rem_pipe[k+1] = rem_ff[k];
      assign nlo_pipe[k+1] = nlo_ff[k];
      assign q_pipe[k+1]   = q_ff[k];
      assign m_pipe[k+1]   = m_ff[k];
   end

   assign out_tag = tag_pipe[Q_BITS];
   assign out_q   = q_pipe[Q_BITS];

endmodule

// ===== rtl/core/tgei_sqrt_pipe.sv =====
`timescale 1ns / 1ps
module tgei_sqrt_pipe (
   input  logic                           clock,
   input  logic                           reset,
   input  tgei_pkg::tag_type              in_tag,
   input  logic [tgei_pkg::Q_BITS-1:0]    in_x,
   output tgei_pkg::tag_type              out_tag,
   output logic [tgei_pkg::ROOT_BITS-1:0] out_root
);
   import tgei_pkg::*;

   localparam int RW = ROOT_BITS + 2;

   tag_type              tag_ff  [0:ROOT_BITS-1];
   logic [RW-1:0]        rem_ff  [0:ROOT_BITS-1];
   logic [ROOT_BITS-1:0] root_ff [0:ROOT_BITS-1];
   logic [Q_BITS-1:0]    x_ff    [0:ROOT_BITS-1];

   tag_type              tag_pipe  [0:ROOT_BITS];
   logic [RW-1:0]        rem_pipe  [0:ROOT_BITS];
   logic [ROOT_BITS-1:0] root_pipe [0:ROOT_BITS];
   logic [Q_BITS-1:0]    x_pipe    [0:ROOT_BITS];

   assign tag_pipe[0]  = in_tag;
   assign rem_pipe[0]  = '0;
   assign root_pipe[0] = '0;
   assign x_pipe[0]    = in_x;

   // Digit-by-digit square root: two radicand bits in, one root bit out per stage.
   for (genvar k = 0; k < ROOT_BITS; k++) begin : g_step
      logic [RW+1:0] trial;
      logic [RW+1:0] test;
      logic [RW+1:0] diff;
      logic          take;

      always_comb begin
         trial = {rem_pipe[k], x_pipe[k][Q_BITS-1:Q_BITS-2]};
         test  = {2'b00, root_pipe[k], 2'b01};
         diff  = trial - test;
         take  = (trial >= test);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[k] <= '0;
         end else begin
            tag_ff[k] <= tag_pipe[k];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= take ? diff[RW-1:0] : trial[RW-1:0];
         root_ff[k] <= {root_pipe[k][ROOT_BITS-2:0], take};
         x_ff[k]    <= {x_pipe[k][Q_BITS-3:0], 2'b00};
      end

      assign tag_pipe[k+1]  = tag_ff[k];
      assign rem_pipe[k+1]  = rem_ff[k];
      assign root_pipe[k+1] = root_ff[k];
      assign x_pipe[k+1]    = x_ff[k];
   end

   assign out_tag  = tag_pipe[ROOT_BITS];
   assign out_root = root_pipe[ROOT_BITS];

endmodule

// ===== rtl/core/tgei_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tgei_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           rsp_valid,
   input logic [tgei_pkg::OUT_WIDTH-1:0] rsp_error_indicator,
   input logic [1:0]                     rsp_status,
   input logic                           rsp_saturated
);
   import tgei_pkg::*;

   // Every accepted word comes out after the fixed latency.
   `ASSERT_DELAY(a_lat, clock, reset, start && !busy, PIPE_LAT, rsp_valid)

   // No result word appears without a word accepted the latency before.
   `ASSERT_IMPLY(a_src, clock, reset, rsp_valid, $past(start && !busy, PIPE_LAT))

   // A clipped result shows all ones and a computed status.
   `ASSERT_IMPLY(a_sat, clock, reset, rsp_valid && rsp_saturated, rsp_error_indicator == '1 && rsp_status == STATUS_OK)

   // A rejected element gives zero and is never flagged as clipped.
   `ASSERT_IMPLY(a_rej, clock, reset, rsp_valid && rsp_status != STATUS_OK, rsp_error_indicator == '0 && !rsp_saturated)

endmodule

bind triangle_gradient_error_indicator tgei_checker u_tgei_checker (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .rsp_valid           (rsp_valid),
   .rsp_error_indicator (rsp_error_indicator),
   .rsp_status          (rsp_status),
   .rsp_saturated       (rsp_saturated)
);

// ===== test/tgei_checker.sv =====
`timescale 1ns / 1ps
module tgei_scoreboard (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           busy,
   input  logic                           req_element_valid,
   input  logic signed [31:0]             req_x0,
   input  logic signed [31:0]             req_y0,
   input  logic signed [31:0]             req_x1,
   input  logic signed [31:0]             req_y1,
   input  logic signed [31:0]             req_x2,
   input  logic signed [31:0]             req_y2,
   input  logic signed [31:0]             req_u0,
   input  logic signed [31:0]             req_u1,
   input  logic signed [31:0]             req_u2,
   input  logic                           rsp_valid,
   input  logic [tgei_pkg::OUT_WIDTH-1:0] rsp_error_indicator,
   input  logic [1:0]                     rsp_status,
   input  logic                           rsp_saturated,
   input  logic                           csr_we,
   input  logic                           csr_index,
   input  logic [tgei_pkg::CSR_WIDTH-1:0] csr_wdata,
   output int                             fail_count,
   output int                             pending
);
   import tgei_pkg::*;

   typedef struct {
      logic                 valid;
      logic signed [31:0]   x0, y0, x1, y1, x2, y2, u0, u1, u2;
   } triangle_type;

   typedef struct {
      logic [OUT_WIDTH-1:0] indicator;
      status_type           status;
      logic                 sat;
   } grade_type;

   grade_type        grade_queue[$];
   logic [31:0]      area_floor;
   logic [31:0]      det_floor;

   // Integer square root, truncated toward zero.
   function automatic logic [31:0] int_sqrt(input logic [63:0] value);
      logic [63:0] rest;
      logic [63:0] root;
      logic [63:0] bitv;
      rest = value;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > rest) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rest >= root + bitv) begin
            rest = rest - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root[31:0];
   endfunction

   // Exact gradient indicator: isqrt(floor(N / (2 |det|))) with both floors checked.
   function automatic grade_type grade_triangle(input triangle_type t,
                                                input logic [31:0] afloor,
                                                input logic [31:0] dfloor);
      grade_type          g;
      logic signed [39:0] ax, ay, bx, by, du1, du2;
      logic signed [127:0] det, gx, gy;
      logic [255:0]       mag_d, gxm, gym, nsum, quo;
      g.indicator = '0;
      g.status = STATUS_OK;
      g.sat = 1'b0;
      if (!t.valid) begin
         g.status = STATUS_INVALID;
         return g;
      end
      ax = $signed(t.x1) - $signed(t.x0);
      ay = $signed(t.y1) - $signed(t.y0);
      bx = $signed(t.x2) - $signed(t.x0);
      by = $signed(t.y2) - $signed(t.y0);
      du1 = $signed(t.u1) - $signed(t.u0);
      du2 = $signed(t.u2) - $signed(t.u0);
      det = ax * by - bx * ay;
      mag_d = (det < 0) ? 256'(-det) : 256'(det);
      if (mag_d < {223'd0, afloor, 1'b0}) begin
         g.status = STATUS_AREA;
         return g;
      end
      if (mag_d < 256'(dfloor) || mag_d == 0) begin
         g.status = STATUS_DET;
         return g;
      end
      gx = by * du1 - ay * du2;
      gy = ax * du2 - bx * du1;
      gxm = (gx < 0) ? 256'(-gx) : 256'(gx);
      gym = (gy < 0) ? 256'(-gy) : 256'(gy);
      nsum = gxm * gxm + gym * gym;
      quo = nsum / (mag_d << 1);
      if (quo[255:64] != 0) begin
         g.indicator = '1;
         g.sat = 1'b1;
      end else begin
         g.indicator = int_sqrt(quo[63:0]);
      end
      return g;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
      fail_count++;
   endtask

   assign pending = grade_queue.size();

   // Track the floors, predict each accepted word and check each result word.
   always @(posedge clock) begin
      triangle_type t;
      grade_type    want;
      if (reset) begin
         area_floor <= 32'd1;
         det_floor <= 32'd1;
         grade_queue.delete();
         fail_count = 0;
      end else begin
         if (csr_we) begin
            if (csr_index == 1'(CSR_MIN_AREA)) area_floor <= csr_wdata;
            else det_floor <= csr_wdata;
         end
         if (start && !busy) begin
            t.valid = req_element_valid;
            t.x0 = req_x0; t.y0 = req_y0;
            t.x1 = req_x1; t.y1 = req_y1;
            t.x2 = req_x2; t.y2 = req_y2;
            t.u0 = req_u0; t.u1 = req_u1; t.u2 = req_u2;
            grade_queue.insert(grade_queue.size(), grade_triangle(t, area_floor, det_floor));
         end
         if (rsp_valid) begin
            if (grade_queue.size() == 0) begin
               report_mismatch("unexpected word", 32'd0, 32'd0);
            end else begin
               want = grade_queue.pop_front();
               if (rsp_error_indicator !== want.indicator)
                  report_mismatch("error_indicator", rsp_error_indicator, want.indicator);
               if (rsp_status !== want.status)
                  report_mismatch("status", 32'(rsp_status), 32'(want.status));
               if (rsp_saturated !== want.sat)
                  report_mismatch("saturated", 32'(rsp_saturated), 32'(want.sat));
            end
         end
      end
   end

endmodule

// ===== test/tb_triangle_gradient_error_indicator.sv =====
`timescale 1ns / 1ps
module tb_triangle_gradient_error_indicator;
   import tgei_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT = PIPE_LAT + 16;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic                 req_element_valid;
   logic signed [31:0]   req_x0, req_y0, req_x1, req_y1, req_x2, req_y2;
   logic signed [31:0]   req_u0, req_u1, req_u2;
   logic                 rsp_valid;
   logic [OUT_WIDTH-1:0] rsp_error_indicator;
   logic [1:0]           rsp_status;
   logic                 rsp_saturated;
   logic                 csr_we;
   logic                 csr_index;
   logic [CSR_WIDTH-1:0] csr_wdata;
   int                   fail_count;
   int                   pending;
   int                   cycle_count;

   triangle_gradient_error_indicator #(.COORD_WIDTH(32)) dut (.*);

   tgei_scoreboard checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[triangle_gradient_error_indicator] ERROR");
         $finish;
      end
   end

   // Offer one triangle word, wait for it to be taken, then idle at random.
   task automatic send_triangle(input logic ok, input logic [31:0] x0, y0, x1, y1,
                                x2, y2, u0, u1, u2);
      int gap;
      req_element_valid <= ok;
      req_x0 <= x0; req_y0 <= y0; req_x1 <= x1; req_y1 <= y1;
      req_x2 <= x2; req_y2 <= y2; req_u0 <= u0; req_u1 <= u1; req_u2 <= u2;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_pipeline;
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // One register write; csr_we is then taken low again on the port.
   task automatic write_floor(input logic index, input logic [31:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Random triangle: small, collinear, nearly degenerate, full-range or invalid.
   task automatic send_random_triangle;
      logic [31:0] v[9];
      int          kind;
      int          span;
      kind = $urandom_range(0, 9);
      span = ($urandom_range(0, 1) == 0) ? 32'h0000_3000 : 32'h0004_0000;
      foreach (v[i]) v[i] = $urandom_range(0, 2 * span) - span;
      if (kind == 0) begin
         foreach (v[i]) v[i] = $urandom();
      end else if (kind == 1) begin
         // Collinear vertices: third point on the line through the first two.
         v[4] = v[2] + (v[2] - v[0]);
         v[5] = v[3] + (v[3] - v[1]);
      end else if (kind == 2) begin
         // Nearly degenerate sliver.
         v[4] = v[2] + (v[2] - v[0]) + $urandom_range(0, 3);
         v[5] = v[3] + (v[3] - v[1]);
      end
      send_triangle(kind != 9 || $urandom_range(0, 1) == 1,
                    v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]);
   endtask

   initial begin
      logic [31:0] floors[5][2];
      reset = 1'b1;
      start = 1'b0;
      csr_we = 1'b0;
      csr_index = 1'b0;
      csr_wdata = '0;
      {req_element_valid, req_x0, req_y0, req_x1, req_y1, req_x2, req_y2} = '0;
      {req_u0, req_u1, req_u2} = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words under the reset floors.
      send_triangle(1'b0, 0, 0, 32'h10000, 0, 0, 32'h10000, 0, 32'h10000, 0);
      send_triangle(1'b1, 0, 0, 32'h10000, 0, 0, 32'h10000, 0, 32'h10000, 0);
      send_triangle(1'b1, 0, 0, 32'h10000, 0, 0, 32'h10000, 0, 0, 0);
      send_triangle(1'b1, 0, 0, 32'h10000, 32'h10000, 32'h20000, 32'h20000, 1, 2, 3);
      send_triangle(1'b1, 0, 0, 1, 0, 0, 1, 0, 1, 1);
      send_triangle(1'b1, 0, 0, 1, 0, 0, 1, 32'h8000_0000, 32'h7FFF_FFFF, 0);
      send_triangle(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h8000_0000);
      send_triangle(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h7FFF_FFFF);
      send_triangle(1'b1, 0, 0, 32'h8000_0000, 0, 0, 32'h8000_0000, 1, 1, 1);
      send_triangle(1'b1, 32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF, 32'h0001_0000,
                    32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000);
      drain_pipeline();

      // Floors at zero: only an exactly zero determinant is rejected.
      write_floor(1'(CSR_MIN_AREA), 32'd0);
      write_floor(1'(CSR_MIN_DET), 32'd0);
      send_triangle(1'b1, 5, 5, 5, 5, 5, 5, 1, 2, 3);
      send_triangle(1'b1, 0, 0, 1, 0, 0, 1, 32'h7FFF_FFFF, 0, 32'h8000_0000);
      send_triangle(1'b1, 0, 0, 2, 0, 0, 1, 0, 32'h10000, 32'h10000);
      drain_pipeline();

      // Settings for the random part, extremes among them.
      floors[0] = '{32'd0, 32'd0};
      floors[1] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF};
      floors[2] = '{32'd0, 32'hFFFF_FFFF};
      floors[3] = '{32'h0000_1000, 32'd0};
      floors[4] = '{32'd1, 32'd1};
      for (int phase = 0; phase < 6; phase++) begin
         if (phase < 5) begin
            write_floor(1'(CSR_MIN_AREA), floors[phase][0]);
            write_floor(1'(CSR_MIN_DET), floors[phase][1]);
         end else begin
            write_floor(1'(CSR_MIN_AREA), $urandom_range(0, 32'h0100_0000));
            write_floor(1'(CSR_MIN_DET), $urandom_range(0, 32'h0200_0000));
         end
         for (int n = 0; n < 250; n++) send_random_triangle();
         drain_pipeline();
      end

      if (fail_count == 0) begin
         $display("[triangle_gradient_error_indicator] OK");
      end else begin
         $display("[triangle_gradient_error_indicator] ERROR");
      end
      $finish;
   end

endmodule
